### rtl/calendar_clock_with_alarm_top_macros.svh
// Assertion macros for the calendar clock RTL
`ifndef CALENDAR_CLOCK_WITH_ALARM_TOP_MACROS_SVH
`define CALENDAR_CLOCK_WITH_ALARM_TOP_MACROS_SVH

// check on every rising edge once out of reset
`define CCA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define CCA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cca_pkg.sv
// Package for the calendar clock: time record, codes and calendar helpers
package cca_pkg;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } cca_time_t;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // field select codes
    localparam logic [2:0] FIELD_SEC   = 3'd0;
    localparam logic [2:0] FIELD_MIN   = 3'd1;
    localparam logic [2:0] FIELD_HOUR  = 3'd2;
    localparam logic [2:0] FIELD_DAY   = 3'd3;
    localparam logic [2:0] FIELD_MONTH = 3'd4;
    localparam logic [2:0] FIELD_YEAR  = 3'd5;

    // register indexes
    localparam logic [2:0] REG_ALARM_HOUR   = 3'd0;
    localparam logic [2:0] REG_ALARM_MINUTE = 3'd1;
    localparam logic [2:0] REG_ALARM_SECOND = 3'd2;
    localparam logic [2:0] REG_SECOND_PER   = 3'd3;
    localparam logic [2:0] REG_BLINK_PER    = 3'd4;
    localparam logic [2:0] REG_ALARM_DUR    = 3'd5;

    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [6:0] YEAR_MAX  = 7'd99;

    localparam logic [15:0] SAT16           = 16'hFFFF;
    localparam logic [15:0] TONE_END_MARGIN = 16'd100;

    localparam logic [15:0] SECOND_PER_RESET = 16'd1000;
    localparam logic [15:0] BLINK_PER_RESET  = 16'd500;
    localparam logic [15:0] ALARM_DUR_RESET  = 16'd10000;

    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        if (m == 4'd2)
            len = 5'd28;
        else if (m == 4'd4 || m == 4'd9 || m == 4'd11)
            len = 5'd30;
        else
            len = 5'd31;
        return len;
    endfunction

    // above range gives the low end, below range gives the high end
    function automatic logic [6:0] wrap_value(input logic signed [7:0] v,
                                              input logic signed [7:0] lo,
                                              input logic signed [7:0] hi);
        logic [6:0] r;
        if (v > hi)
            r = lo[6:0];
        else if (v < lo)
            r = hi[6:0];
        else
            r = v[6:0];
        return r;
    endfunction

endpackage

### rtl/cca_time.sv
// Time-of-day and date cascade with direct field writes
module cca_time
    import cca_pkg::*;
(
    input  cca_time_t         cur,
    input  logic              tick_second,
    input  logic              field_write,
    input  logic [2:0]        field_select,
    input  logic signed [7:0] field_value,
    output cca_time_t         nxt
);

    logic [6:0] wr_sec;
    logic [6:0] wr_hour;
    logic [6:0] wr_day;
    logic [6:0] wr_month;
    logic [6:0] wr_year;

    assign wr_sec   = wrap_value(field_value, 8'sd0, 8'sd59);
    assign wr_hour  = wrap_value(field_value, 8'sd0, 8'sd23);
    assign wr_day   = wrap_value(field_value, 8'sd1, 8'sd31);
    assign wr_month = wrap_value(field_value, 8'sd1, 8'sd12);
    assign wr_year  = wrap_value(field_value, 8'sd0, 8'sd99);

    always_comb
    begin
        nxt = cur;
        if (tick_second)
        begin
            // carry ripples only as far as the first field that is not at its end
            if (cur.sec < SEC_MAX)
                nxt.sec = cur.sec + 6'd1;
            else
            begin
                nxt.sec = '0;
                if (cur.min < MIN_MAX)
                    nxt.min = cur.min + 6'd1;
                else
                begin
                    nxt.min = '0;
                    if (cur.hour < HOUR_MAX)
                        nxt.hour = cur.hour + 5'd1;
                    else
                    begin
                        nxt.hour = '0;
                        if (cur.day < month_length(cur.month))
                            nxt.day = cur.day + 5'd1;
                        else
                        begin
                            nxt.day = 5'd1;
                            if (cur.month < MONTH_MAX)
                                nxt.month = cur.month + 4'd1;
                            else
                            begin
                                nxt.month = 4'd1;
                                nxt.year  = (cur.year < YEAR_MAX) ? cur.year + 7'd1 : '0;
                            end
                        end
                    end
                end
            end
        end
        else if (field_write)
        begin
            unique case (field_select)
                FIELD_SEC:   nxt.sec   = wr_sec[5:0];
                FIELD_MIN:   nxt.min   = wr_sec[5:0];
                FIELD_HOUR:  nxt.hour  = wr_hour[4:0];
                FIELD_DAY:   nxt.day   = wr_day[4:0];
                FIELD_MONTH: nxt.month = wr_month[3:0];
                FIELD_YEAR:  nxt.year  = wr_year;
                default:     nxt = cur;
            endcase
        end
    end

endmodule

### rtl/calendar_clock_with_alarm_top.sv
// Calendar clock with alarm: top level
//
// Input channel (in_valid/in_ready) carries one word per item: a millisecond
// tick (command 0) or a write of one time field (command 1), along with the
// setting_mode and alarm_enabled levels. Output channel (out_valid/out_ready)
// returns one word per item: the full time and date plus blink_on and tone_on.
// The result word is valid in the cycle after the input is accepted. One item
// is taken per cycle while the receiver does not stall; the whole tick update
// (prescaler, calendar carry chain, blink and alarm logic) settles in one
// pass between the state registers, which also serve as the result register.
// When the receiver stalls, the pending result holds and in_ready drops until
// it is taken; a new word is accepted in the same cycle the old one leaves.
// Configuration registers are written via cfg_write/cfg_index/cfg_data, by the
// user only while the block is idle, unchecked by it; unknown indexes are dropped.
// Reset clears the time to 00:00:00 day 1 month 1 year 0, stops blink and
// tone, and loads the default periods (1000, 500) and alarm duration 10000.
module calendar_clock_with_alarm_top
    import cca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [2:0]        field_select,
    input  logic signed [7:0] field_value,
    input  logic              setting_mode,
    input  logic              alarm_enabled,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [5:0]        second,
    output logic [5:0]        minute,
    output logic [4:0]        hour,
    output logic [4:0]        day,
    output logic [3:0]        month,
    output logic [6:0]        year,
    output logic              blink_on,
    output logic              tone_on
);

`include "calendar_clock_with_alarm_top_macros.svh"

    logic [4:0]  alarm_hour_reg;
    logic [5:0]  alarm_minute_reg;
    logic [5:0]  alarm_second_reg;
    logic [15:0] second_per_reg;
    logic [15:0] blink_per_reg;
    logic [15:0] alarm_dur_reg;

    cca_time_t   time_reg;
    cca_time_t   time_next;
    logic [15:0] presc_reg;
    logic [15:0] presc_next;
    logic [15:0] blink_cnt_reg;
    logic [15:0] blink_cnt_next;
    logic        blink_reg;
    logic        blink_next;
    logic [15:0] countdown_reg;
    logic [15:0] countdown_next;
    logic        tone_reg;
    logic        tone_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic        accept;
    logic        tick;
    logic        sec_due;
    logic        blink_due;
    logic        alarm_match;
    logic [15:0] presc_inc;
    logic [15:0] blink_inc;
    logic [15:0] countdown_dec;
    logic        countdown_low;
    logic        time_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign tick     = (command == CMD_TICK);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_hour_reg   <= '0;
            alarm_minute_reg <= '0;
            alarm_second_reg <= '0;
            second_per_reg   <= SECOND_PER_RESET;
            blink_per_reg    <= BLINK_PER_RESET;
            alarm_dur_reg    <= ALARM_DUR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ALARM_HOUR:
                    alarm_hour_reg <= (cfg_data[4:0] > HOUR_MAX) ? '0 : cfg_data[4:0];
                REG_ALARM_MINUTE:
                    alarm_minute_reg <= (cfg_data[5:0] > MIN_MAX) ? '0 : cfg_data[5:0];
                REG_ALARM_SECOND:
                    alarm_second_reg <= (cfg_data[5:0] > SEC_MAX) ? '0 : cfg_data[5:0];
                REG_SECOND_PER: second_per_reg <= cfg_data;
                REG_BLINK_PER:  blink_per_reg  <= cfg_data;
                REG_ALARM_DUR:  alarm_dur_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // prescaler and blink counters saturate, then compare against their period
    assign presc_inc  = (presc_reg != SAT16) ? presc_reg + 16'd1 : presc_reg;
    assign sec_due    = (presc_inc >= second_per_reg);
    assign presc_next = sec_due ? '0 : presc_inc;

    assign blink_inc      = (blink_cnt_reg != SAT16) ? blink_cnt_reg + 16'd1 : blink_cnt_reg;
    assign blink_due      = setting_mode && (blink_inc >= blink_per_reg);
    assign blink_cnt_next = blink_due ? '0 : blink_inc;
    assign blink_next     = blink_due ? !blink_reg : blink_reg;

    cca_time u_time (
        .cur          (time_reg),
        .tick_second  (tick && sec_due),
        .field_write  (command == CMD_WRITE),
        .field_select (field_select),
        .field_value  (field_value),
        .nxt          (time_next)
    );

    // alarm compares against the time after this tick's advance
    assign countdown_dec = (countdown_reg != '0) ? countdown_reg - 16'd1 : countdown_reg;
    assign alarm_match   = alarm_enabled
                           && (time_next.hour == alarm_hour_reg)
                           && (time_next.min == alarm_minute_reg)
                           && (time_next.sec == alarm_second_reg);

    always_comb
    begin
        countdown_next = alarm_match ? alarm_dur_reg : countdown_dec;
        tone_next      = alarm_match ? 1'b1 : tone_reg;
        if (countdown_next < TONE_END_MARGIN)
            tone_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '{sec: '0, min: '0, hour: '0, day: 5'd1, month: 4'd1, year: '0};
            presc_reg     <= '0;
            blink_cnt_reg <= '0;
            blink_reg     <= 1'b0;
            countdown_reg <= '0;
            tone_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                time_reg <= time_next;
                if (tick)
                begin
                    presc_reg     <= presc_next;
                    blink_cnt_reg <= blink_cnt_next;
                    blink_reg     <= blink_next;
                    countdown_reg <= countdown_next;
                    tone_reg      <= tone_next;
                end
            end
        end
    end

    // state only moves on accept, so it doubles as the held result word
    assign out_valid = out_valid_reg;
    assign second    = time_reg.sec;
    assign minute    = time_reg.min;
    assign hour      = time_reg.hour;
    assign day       = time_reg.day;
    assign month     = time_reg.month;
    assign year      = time_reg.year;
    assign blink_on  = blink_reg;
    assign tone_on   = tone_reg;

    assign countdown_low = (countdown_reg < TONE_END_MARGIN);
    assign time_ok       = (time_reg.sec <= SEC_MAX) && (time_reg.min <= MIN_MAX)
                           && (time_reg.hour <= HOUR_MAX) && (time_reg.day != 5'd0)
                           && (time_reg.month != 4'd0) && (time_reg.month <= MONTH_MAX)
                           && (time_reg.year <= YEAR_MAX);

    `CCA_ASSERT_ALWAYS(a_tone_margin, tone_reg |-> !countdown_low, "tone on below margin")
    `CCA_ASSERT(a_time_range, time_ok, "time field out of range")
    `CCA_ASSERT(a_stall_blocks, out_valid_reg && !out_ready |-> !in_ready, "stall let input in")
    `CCA_ASSERT(a_accept_result, accept |=> out_valid_reg, "accepted word produced no result")

endmodule
